// ----- src/ffha_pkg.sv -----
package ffha_pkg;

  // heap geometry
  localparam int unsigned HEAP_BYTES  = 16777216;
  localparam int unsigned MAX_REGIONS = 16;
  localparam int unsigned IDX_W       = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned LEN_W       = 25;
  localparam int unsigned EB_W        = 16;
  localparam int unsigned EC_W        = 25;
  localparam int unsigned SIZE_W      = EB_W + EC_W;

  // commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LOW   = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [EB_W-1:0]   elem_bytes;
    logic [EC_W-1:0]   elem_count;
    logic [ADDR_W-1:0] block_start;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_start;
    logic [LEN_W-1:0]  total_free;
  } rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] len;
  } region_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    region_t          wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ----- src/ffha_table.sv -----
module ffha_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffha_pkg::mem_req_t mem_req_i,
  output ffha_pkg::region_t  rd_data_o
);

  ffha_pkg::region_t                mem [ffha_pkg::MAX_REGIONS];
  ffha_pkg::region_t                rd_q;
  logic [ffha_pkg::IDX_W-1:0]       raddr_q;
  logic                             init0_q;

  // region memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr] <= mem_req_i.wdata;
    end
    rd_q    <= mem[mem_req_i.raddr];
    raddr_q <= mem_req_i.raddr;
  end

  // entry 0 holds the whole heap until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init0_q <= 1'b0;
    end else if (mem_req_i.we && mem_req_i.waddr == '0) begin
      init0_q <= 1'b1;
    end
  end

  always_comb begin
    rd_data_o = rd_q;
    if (!init0_q && raddr_q == '0) begin
      rd_data_o.base = '0;
      rd_data_o.len  = ffha_pkg::LEN_W'(ffha_pkg::HEAP_BYTES);
    end
  end

endmodule

// ----- src/ffha_ctrl.sv -----
module ffha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ffha_pkg::req_t     req_i,
  output logic               valid_o,
  output ffha_pkg::rsp_t     rsp_o,
  output ffha_pkg::mem_req_t mem_req_o,
  input  ffha_pkg::region_t  rd_data_i
);

  localparam int unsigned S_W = 3;
  localparam logic [S_W-1:0] S_IDLE = 3'd0;
  localparam logic [S_W-1:0] S_MUL  = 3'd1;
  localparam logic [S_W-1:0] S_EVAL = 3'd2;
  localparam logic [S_W-1:0] S_SCAN = 3'd3;
  localparam logic [S_W-1:0] S_SHDN = 3'd4;
  localparam logic [S_W-1:0] S_SHUP = 3'd5;
  localparam logic [S_W-1:0] S_INS  = 3'd6;
  localparam logic [S_W-1:0] S_DONE = 3'd7;

  localparam int unsigned LW = ffha_pkg::LEN_W;
  localparam int unsigned CW = ffha_pkg::CNT_W;
  localparam int unsigned IW = ffha_pkg::IDX_W;

  logic [S_W-1:0]                state_q, state_d;
  ffha_pkg::req_t                req_q;
  logic [ffha_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [LW-1:0]                 free_q, free_d;
  ffha_pkg::region_t             prev_q, prev_d;
  logic [1:0]                    status_q, status_d;
  logic [ffha_pkg::ADDR_W-1:0]   astart_q, astart_d;

  logic [LW-1:0]                 sz;
  logic [LW-1:0]                 bs;
  logic [LW:0]                   blk_end;
  logic [LW:0]                   prev_end;
  logic                          has_prev, has_next;
  logic                          join_prev, join_next;

  assign sz       = size_q[LW-1:0];
  assign bs       = {1'b0, req_q.block_start};
  assign blk_end  = {1'b0, bs} + {1'b0, sz};
  assign prev_end = {1'b0, prev_q.base} + {1'b0, prev_q.len};
  assign has_prev = idx_q != '0;
  assign has_next = idx_q < cnt_q;
  assign join_prev = has_prev && prev_end == blk_end - {1'b0, sz};
  assign join_next = has_next && {1'b0, rd_data_i.base} == blk_end;

  // request capture
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
  end

  // control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= CW'(1);
      free_q   <= LW'(ffha_pkg::HEAP_BYTES);
      idx_q    <= '0;
      size_q   <= '0;
      prev_q   <= '0;
      status_q <= ffha_pkg::ST_OK;
      astart_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      free_q   <= free_d;
      idx_q    <= idx_d;
      size_q   <= size_d;
      prev_q   <= prev_d;
      status_q <= status_d;
      astart_q <= astart_d;
    end
  end

  // sequencer: scan, shift and write back
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    free_d    = free_q;
    idx_d     = idx_q;
    size_d    = size_q;
    prev_d    = prev_q;
    status_d  = status_q;
    astart_d  = astart_q;
    mem_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        size_d   = ffha_pkg::SIZE_W'(req_q.elem_bytes) * ffha_pkg::SIZE_W'(req_q.elem_count);
        status_d = ffha_pkg::ST_OK;
        astart_d = '0;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        // first read of entry 0 goes out here
        idx_d = '0;
        mem_req_o.raddr = '0;
        if (req_q.cmd == ffha_pkg::CMD_ALLOC) begin
          if (size_q > ffha_pkg::SIZE_W'(free_q)) begin
            status_d = ffha_pkg::ST_LOW;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          if (size_q == '0) begin
            state_d = S_DONE;
          end else if ({1'b0, size_q} + (ffha_pkg::SIZE_W + 1)'(req_q.block_start) >
                       (ffha_pkg::SIZE_W + 1)'(ffha_pkg::HEAP_BYTES)) begin
            status_d = ffha_pkg::ST_NOFIT;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_req_o.raddr = IW'(idx_q + CW'(1));
        if (req_q.cmd == ffha_pkg::CMD_ALLOC) begin
          if (!has_next) begin
            status_d = ffha_pkg::ST_NOFIT;
            state_d  = S_DONE;
          end else if (rd_data_i.len >= sz) begin
            astart_d = rd_data_i.base[ffha_pkg::ADDR_W-1:0];
            state_d  = S_DONE;
            if (sz != '0) begin
              free_d = free_q - sz;
              if (rd_data_i.len == sz) begin
                // region emptied: drop it
                if (idx_q + CW'(1) < cnt_q) begin
                  state_d = S_SHDN;
                end else begin
                  cnt_d = cnt_q - CW'(1);
                end
              end else begin
                mem_req_o.we         = 1'b1;
                mem_req_o.waddr      = idx_q[IW-1:0];
                mem_req_o.wdata.base = rd_data_i.base + sz;
                mem_req_o.wdata.len  = rd_data_i.len - sz;
              end
            end
          end else begin
            idx_d = idx_q + CW'(1);
          end
        end else begin
          if (has_next && rd_data_i.base <= bs) begin
            prev_d = rd_data_i;
            idx_d  = idx_q + CW'(1);
          end else begin
            state_d = S_DONE;
            if ((has_prev && prev_end > {1'b0, bs}) ||
                (has_next && {1'b0, rd_data_i.base} < blk_end)) begin
              status_d = ffha_pkg::ST_NOFIT;
            end else if (join_prev && join_next) begin
              mem_req_o.we         = 1'b1;
              mem_req_o.waddr      = IW'(idx_q - CW'(1));
              mem_req_o.wdata.base = prev_q.base;
              mem_req_o.wdata.len  = prev_q.len + sz + rd_data_i.len;
              free_d = free_q + sz;
              if (idx_q + CW'(1) < cnt_q) begin
                state_d = S_SHDN;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end else if (join_prev) begin
              mem_req_o.we         = 1'b1;
              mem_req_o.waddr      = IW'(idx_q - CW'(1));
              mem_req_o.wdata.base = prev_q.base;
              mem_req_o.wdata.len  = prev_q.len + sz;
              free_d = free_q + sz;
            end else if (join_next) begin
              mem_req_o.we         = 1'b1;
              mem_req_o.waddr      = idx_q[IW-1:0];
              mem_req_o.wdata.base = bs;
              mem_req_o.wdata.len  = rd_data_i.len + sz;
              free_d = free_q + sz;
            end else if (cnt_q >= CW'(ffha_pkg::MAX_REGIONS)) begin
              status_d = ffha_pkg::ST_FULL;
            end else if (has_next) begin
              // open a gap: move tail entries up by one
              mem_req_o.raddr = IW'(cnt_q - CW'(1));
              prev_d.base     = LW'(cnt_q - CW'(1));
              state_d         = S_SHUP;
            end else begin
              state_d = S_INS;
            end
          end
        end
      end
      S_SHDN: begin
        // idx_q is the slot being refilled from the next one
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = idx_q[IW-1:0];
        mem_req_o.wdata = rd_data_i;
        mem_req_o.raddr = IW'(idx_q + CW'(2));
        if (idx_q + CW'(2) < cnt_q) begin
          idx_d = idx_q + CW'(1);
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end
      S_SHUP: begin
        // prev_q.base holds the source slot
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IW'(prev_q.base + LW'(1));
        mem_req_o.wdata = rd_data_i;
        mem_req_o.raddr = IW'(prev_q.base - LW'(1));
        if (prev_q.base > LW'(idx_q)) begin
          prev_d.base = prev_q.base - LW'(1);
        end else begin
          state_d = S_INS;
        end
      end
      S_INS: begin
        mem_req_o.we         = 1'b1;
        mem_req_o.waddr      = idx_q[IW-1:0];
        mem_req_o.wdata.base = bs;
        mem_req_o.wdata.len  = sz;
        cnt_d   = cnt_q + CW'(1);
        free_d  = free_q + sz;
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy              = state_q != S_IDLE;
  assign valid_o           = state_q == S_DONE;
  assign rsp_o.status      = status_q;
  assign rsp_o.alloc_start = astart_q;
  assign rsp_o.total_free  = free_q;

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// First-fit heap allocator with a coalescing free-region table.
// Request channel: present req_i and raise start; the request is taken at
// the rising edge where start is high and busy is low. cmd selects
// allocate or free; the size is elem_bytes times elem_count.
// Result channel: valid_o is high for exactly one cycle with rsp_o
// (status, alloc_start, total_free); the receiver cannot stall it, so it
// must take the result in that cycle. busy stays high until that cycle ends.
// Scanning visits the region table one entry a cycle (the table is a
// single-port read memory); entries are moved one by one when a region
// is removed or inserted, and a new region is then written in its own
// state. One request is handled at a time.
// Reset: the table holds one region covering the whole heap and the free
// total equals the heap size; no clearing pass is needed.
module first_fit_heap_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ffha_pkg::req_t req_i,
  output logic           valid_o,
  output ffha_pkg::rsp_t rsp_o
);

  ffha_pkg::mem_req_t mem_req;
  ffha_pkg::region_t  rd_data;

  // sequencer
  ffha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .valid_o   (valid_o),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rd_data_i (rd_data)
  );

  // region table
  ffha_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

// ----- src/ffha_checker.sv -----
module ffha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           valid_o,
  input ffha_pkg::rsp_t rsp_o
);

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  // a result only comes while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result while idle");

  // one result per request, then free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o && !busy)
    else $error("result strobe longer than one cycle");

  // failed requests report no start address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.status != ffha_pkg::ST_OK |-> rsp_o.alloc_start == '0)
    else $error("start address on failed request");

  // free total never exceeds the heap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rsp_o.total_free <= ffha_pkg::LEN_W'(ffha_pkg::HEAP_BYTES))
    else $error("free total beyond heap size");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);
